// ----- sv/nps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the prime table for the next prime search block.
package nps_pkg;

    localparam int DATA_W     = 32;
    localparam int DIVIDEND_W = 31;
    localparam int DIVISOR_W  = 17;
    localparam int SQ_W       = 34;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int ROM_SIZE   = 103;
    localparam int ROM_IDX_W  = $clog2(ROM_SIZE);

    localparam logic signed [DATA_W-1:0]     ROM_LAST    = 32'sd14000839;
    localparam logic signed [DATA_W-1:0]     TABLE_END   = -32'sd1;
    localparam logic [DIVIDEND_W-1:0]        CAND_LIMIT  = 31'h7FFF_FFFF;
    localparam logic [DIVISOR_W-1:0]         SKIP_MOD    = 17'd101;
    localparam logic [DIVISOR_W-1:0]         FIRST_DIV   = 17'd3;
    localparam logic [SQ_W-1:0]              FIRST_SQ    = 34'd9;

    localparam logic [DATA_W-1:0] PRIME_ROM [ROM_SIZE] = '{
        32'd7,       32'd13,      32'd29,      32'd43,      32'd73,      32'd107,
        32'd127,     32'd131,     32'd137,     32'd139,     32'd149,     32'd151,
        32'd157,     32'd163,     32'd167,     32'd173,     32'd179,     32'd181,
        32'd191,     32'd193,     32'd197,     32'd199,     32'd211,     32'd223,
        32'd227,     32'd229,     32'd233,     32'd239,     32'd241,     32'd251,
        32'd257,     32'd263,     32'd269,     32'd271,     32'd277,     32'd281,
        32'd283,     32'd293,     32'd307,     32'd311,     32'd313,     32'd317,
        32'd331,     32'd337,     32'd347,     32'd349,     32'd353,     32'd431,
        32'd521,     32'd631,     32'd761,     32'd919,     32'd1103,    32'd1327,
        32'd1597,    32'd1931,    32'd2333,    32'd2801,    32'd3371,    32'd4049,
        32'd4861,    32'd5839,    32'd7013,    32'd8419,    32'd10103,   32'd12143,
        32'd14591,   32'd17519,   32'd21023,   32'd25229,   32'd30293,   32'd36353,
        32'd43627,   32'd52361,   32'd62851,   32'd75431,   32'd90523,   32'd108631,
        32'd130363,  32'd156437,  32'd187751,  32'd225307,  32'd270371,  32'd324449,
        32'd389357,  32'd467237,  32'd560689,  32'd672827,  32'd807403,  32'd968897,
        32'd1162687, 32'd1395263, 32'd1674319, 32'd2009191, 32'd2411033, 32'd2893249,
        32'd3471899, 32'd4166287, 32'd4999559, 32'd5999471, 32'd7199369, 32'd9270769,
        32'd14000839
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROM,
        ST_CAND,
        ST_MOD_WAIT,
        ST_TRIAL,
        ST_TRIAL_WAIT,
        ST_FINISH
    } nps_state_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } nps_div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIVISOR_W-1:0] remainder;
    } nps_div_rsp_t;

endpackage

// ----- sv/nps_div.sv -----
`timescale 1ns / 1ps
// Bit-serial restoring divider that returns the remainder, one dividend bit per cycle.
module nps_div
    import nps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  nps_div_req_t req,
    output nps_div_rsp_t rsp
);

    logic                  busy_reg,  busy_next;
    logic                  done_reg,  done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [DIVIDEND_W-1:0] dvd_reg,   dvd_next;
    logic [DIVISOR_W-1:0]  dsr_reg,   dsr_next;
    logic [DIVISOR_W-1:0]  rem_reg,   rem_next;
    logic [DIVISOR_W:0]    trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it always fits.
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = DIVISOR_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
            end
            dvd_next = {dvd_reg[DIVIDEND_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ----- sv/next_prime_search.sv -----
`timescale 1ns / 1ps
// Top level of the next prime search: table scan and trial-division sequencer.
//
//   channel | signals                          | payload
//   --------+----------------------------------+---------------------
//   input   | from_valid, from_stall           | from  (32b signed)
//   output  | prime_valid, prime_stall         | prime (32b signed)
//
// Inputs up to the last table entry are answered by scanning the prime table, one
// entry a cycle. Larger inputs run a trial-division search on one shared
// bit-serial divider: each candidate costs one division by 101 plus at most
// one division per odd divisor up to its square root.
// One item is worked on at a time; from_stall is high until the result is
// handed to the output register, which may still hold a stalled earlier item.
// Reset clears the sequencer and the output valid; no state survives between items.
module next_prime_search
    import nps_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     from_valid,
    output logic                     from_stall,
    input  logic signed [DATA_W-1:0] from,
    output logic                     prime_valid,
    input  logic                     prime_stall,
    output logic signed [DATA_W-1:0] prime
);

    nps_state_t               state_reg, state_next;
    logic signed [DATA_W-1:0] from_reg,  from_next;
    logic signed [DATA_W-1:0] res_reg,   res_next;
    logic [DIVIDEND_W-1:0]    cand_reg,  cand_next;
    logic [DIVISOR_W-1:0]     d_reg,     d_next;
    logic [SQ_W-1:0]          sq_reg,    sq_next;
    logic [ROM_IDX_W-1:0]     idx_reg,   idx_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_reg,   out_next;
    logic signed [DATA_W-1:0] rom_val;

    nps_div_req_t div_req;
    nps_div_rsp_t div_rsp;

    nps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign rom_val = $signed(PRIME_ROM[idx_reg]);

    always_comb
    begin
        state_next     = state_reg;
        from_next      = from_reg;
        res_next       = res_reg;
        cand_next      = cand_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        div_req        = '0;

        if (prime_valid && !prime_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (from_valid)
                begin
                    from_next = from;
                    idx_next  = '0;
                    // Only positive values use this candidate, so bit 31 is zero.
                    cand_next = from[DIVIDEND_W-1:0] | DIVIDEND_W'(1);
                    if (from > ROM_LAST)
                    begin
                        state_next = ST_CAND;
                    end
                    else
                    begin
                        state_next = ST_ROM;
                    end
                end
            end
            ST_ROM:
            begin
                if (rom_val > from_reg)
                begin
                    res_next   = rom_val;
                    state_next = ST_FINISH;
                end
                else if (idx_reg == ROM_IDX_W'(ROM_SIZE - 1))
                begin
                    res_next   = TABLE_END;
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_CAND:
            begin
                if (cand_reg == CAND_LIMIT)
                begin
                    res_next   = from_reg;
                    state_next = ST_FINISH;
                end
                else
                begin
                    // Primes one above a multiple of 101 are rejected before testing.
                    div_req.start    = 1'b1;
                    div_req.dividend = cand_reg - DIVIDEND_W'(1);
                    div_req.divisor  = SKIP_MOD;
                    state_next       = ST_MOD_WAIT;
                end
            end
            ST_MOD_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.remainder == '0)
                    begin
                        cand_next  = cand_reg + DIVIDEND_W'(2);
                        state_next = ST_CAND;
                    end
                    else
                    begin
                        d_next     = FIRST_DIV;
                        sq_next    = FIRST_SQ;
                        state_next = ST_TRIAL;
                    end
                end
            end
            ST_TRIAL:
            begin
                if (sq_reg > SQ_W'(cand_reg))
                begin
                    res_next   = $signed({1'b0, cand_reg});
                    state_next = ST_FINISH;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = cand_reg;
                    div_req.divisor  = d_reg;
                    state_next       = ST_TRIAL_WAIT;
                end
            end
            ST_TRIAL_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.remainder == '0)
                    begin
                        cand_next  = cand_reg + DIVIDEND_W'(2);
                        state_next = ST_CAND;
                    end
                    else
                    begin
                        // (d + 2)^2 = d^2 + 4d + 4 keeps the square without a multiplier.
                        sq_next    = sq_reg + SQ_W'({d_reg, 2'b00}) + SQ_W'(4);
                        d_next     = d_reg + DIVISOR_W'(2);
                        state_next = ST_TRIAL;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !prime_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        from_reg <= from_next;
        res_reg  <= res_next;
        cand_reg <= cand_next;
        d_reg    <= d_next;
        sq_reg   <= sq_next;
        idx_reg  <= idx_next;
        out_reg  <= out_next;
    end

    assign from_stall  = (state_reg != ST_IDLE);
    assign prime_valid = out_valid_reg;
    assign prime       = out_reg;

endmodule
